>>> sv/urta_pkg.sv
package urta_pkg;

   // width of the value field on the input channel
   localparam int DATA_BITS = 32;
   // default operand width
   localparam int VALUE_BITS_DEF = 32;

   // format codes
   localparam logic [2:0] OP_HEX_UPPER = 3'd0;
   localparam logic [2:0] OP_HEX_LOWER = 3'd1;
   localparam logic [2:0] OP_DEC       = 3'd2;
   localparam logic [2:0] OP_OCT       = 3'd3;
   localparam logic [2:0] OP_BIN       = 3'd4;

   // half of each radix, the carry threshold of a digit cell
   localparam logic [3:0] HALF_HEX = 4'd8;
   localparam logic [3:0] HALF_DEC = 4'd5;
   localparam logic [3:0] HALF_OCT = 4'd4;
   localparam logic [3:0] HALF_BIN = 4'd1;

   // digit cell modes
   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_DOUBLE = 2'd2;
   localparam logic [1:0] MODE_SHIFT  = 2'd3;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // control shared by every cell of the chain
   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] half;
   } cell_ctrl_type;

   // digit value to ascii character
   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic lower);
      logic [7:0] c;
      if (digit < 4'd10) begin
         c = CHAR_ZERO + {4'h0, digit};
      end else if (lower) begin
         c = CHAR_LOWER_A + {4'h0, digit} - 8'd10;
      end else begin
         c = CHAR_UPPER_A + {4'h0, digit} - 8'd10;
      end
      return c;
   endfunction

endpackage

>>> sv/unsigned_radix_to_ascii.sv
// operation: the item is taken, its NUM_BITS = min(VALUE_BITS, 32) value bits are shifted
// through the digit cell chain, then the characters are sent most significant first, each
// held while the output stalls; an item with an unused format code is dropped
// items: no new item is taken until the last character of the current one is loaded
// reset: synchronous, active high; clears the controller and the output valid
module unsigned_radix_to_ascii #(
   parameter int VALUE_BITS = urta_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value [31:0], operation [34:32], zero [39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // character [7:0], char_count [13:8], zero [15:14]
   output logic        rsp_tlast
);

   localparam int NUM_BITS = (VALUE_BITS < urta_pkg::DATA_BITS) ? VALUE_BITS
                                                                : urta_pkg::DATA_BITS;
   localparam int LEN_W    = $clog2(NUM_BITS + 1);
   localparam int IDX_W    = $clog2(NUM_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [NUM_BITS-1:0] val_ff, val_in;
   logic [LEN_W-1:0]    bits_ff, bits_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [3:0]          half_ff, half_in;
   logic                lower_ff, lower_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic [5:0]          rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   urta_pkg::cell_ctrl_type        cell_ctrl;
   logic [NUM_BITS:0]              carry_w;
   logic [NUM_BITS-1:0][3:0]       digit_w;
   logic [LEN_W-1:0]               len_dec;
   logic [IDX_W-1:0]               top_idx;
   logic                           accept;
   logic                           load;
   logic [2:0]                     req_op;

   assign req_op     = req_tdata[34:32];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load       = !rsp_tvalid_ff || rsp_tready;
   assign len_dec    = len_ff - LEN_W'(1);
   assign top_idx    = len_dec[IDX_W-1:0];

   // value bits enter the chain most significant first
   assign carry_w[0] = val_ff[NUM_BITS-1];

   // row of digit cells, cell 0 holds the least significant digit
   for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
      logic [3:0] shift_src;
      if (k == 0) begin : g_first
         assign shift_src = 4'd0;
      end else begin : g_rest
         assign shift_src = digit_w[k-1];
      end
      urta_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .carry_in  (carry_w[k]),
         .shift_in  (shift_src),
         .carry_out (carry_w[k+1]),
         .digit     (digit_w[k])
      );
   end

   // controller
   always_comb begin
      state_in       = state_ff;
      val_in         = val_ff;
      bits_in        = bits_ff;
      len_in         = len_ff;
      rem_in         = rem_ff;
      half_in        = half_ff;
      lower_in       = lower_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_char_in    = rsp_char_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      cell_ctrl.mode = urta_pkg::MODE_HOLD;
      cell_ctrl.half = half_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in         = req_tdata[NUM_BITS-1:0];
               bits_in        = LEN_W'(NUM_BITS);
               len_in         = LEN_W'(1);
               lower_in       = (req_op == urta_pkg::OP_HEX_LOWER);
               cell_ctrl.mode = urta_pkg::MODE_CLEAR;
               state_in       = ST_CONV;
               unique case (req_op)
                  urta_pkg::OP_HEX_UPPER: half_in = urta_pkg::HALF_HEX;
                  urta_pkg::OP_HEX_LOWER: half_in = urta_pkg::HALF_HEX;
                  urta_pkg::OP_DEC:       half_in = urta_pkg::HALF_DEC;
                  urta_pkg::OP_OCT:       half_in = urta_pkg::HALF_OCT;
                  urta_pkg::OP_BIN:       half_in = urta_pkg::HALF_BIN;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            // double the chain and add the next bit
            cell_ctrl.mode = urta_pkg::MODE_DOUBLE;
            val_in         = {val_ff[NUM_BITS-2:0], 1'b0};
            bits_in        = bits_ff - LEN_W'(1);
            if (carry_w[len_ff] && (len_ff != LEN_W'(NUM_BITS))) begin
               len_in = len_ff + LEN_W'(1);
            end
            if (bits_ff == LEN_W'(1)) begin
               rem_in   = len_in;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // most significant digit sits at the top used cell, chain moves up
            if (load) begin
               cell_ctrl.mode = urta_pkg::MODE_SHIFT;
               rsp_tvalid_in  = 1'b1;
               rsp_char_in    = urta_pkg::digit_char(digit_w[top_idx], lower_ff);
               rsp_last_in    = (rem_ff == LEN_W'(1));
               rsp_count_in   = (rem_ff == LEN_W'(1)) ? 6'(len_ff) : 6'd0;
               rem_in         = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      val_ff       <= val_in;
      bits_ff      <= bits_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      half_ff      <= half_in;
      lower_ff     <= lower_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // output register
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // digit count stays within the chain while an item is at work
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (len_ff >= LEN_W'(1)) && (len_ff <= LEN_W'(NUM_BITS)))
      else $error("digit count out of range");

   // an unused format code produces nothing
   a_bad_op_drop: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op != urta_pkg::OP_HEX_UPPER) && (req_op != urta_pkg::OP_HEX_LOWER)
         && (req_op != urta_pkg::OP_DEC) && (req_op != urta_pkg::OP_OCT)
         && (req_op != urta_pkg::OP_BIN) |=> (state_ff == ST_IDLE))
      else $error("unused format code started a conversion");

   // the final character is marked and closes the item
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && load && (rem_ff == LEN_W'(1))
         |=> rsp_last_ff && rsp_tvalid_ff && (state_ff == ST_IDLE)
            && (rsp_count_ff == 6'($past(len_ff))))
      else $error("final character not marked");

   // emission never runs with nothing left
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != '0) && (rem_ff <= len_ff))
      else $error("emission counter out of range");

endmodule

>>> sv/urta_cell.sv
module urta_cell (
   input  logic                   clock,
   input  urta_pkg::cell_ctrl_type ctrl,
   input  logic                   carry_in,
   input  logic [3:0]             shift_in,
   output logic                   carry_out,
   output logic [3:0]             digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] reduced;

   // carry depends only on the stored digit, so nothing ripples along the chain
   assign carry_out = (digit_ff >= ctrl.half);
   assign reduced   = carry_out ? (digit_ff - ctrl.half) : digit_ff;
   assign digit     = digit_ff;

   // next digit by mode
   always_comb begin
      unique case (ctrl.mode)
         urta_pkg::MODE_HOLD:   digit_in = digit_ff;
         urta_pkg::MODE_CLEAR:  digit_in = 4'd0;
         urta_pkg::MODE_DOUBLE: digit_in = {reduced[2:0], carry_in};
         urta_pkg::MODE_SHIFT:  digit_in = shift_in;
         default:               digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule
